// ===== hdl/tcp_client_segment_engine_defines.svh =====
// Assertion macros shared by the segment engine modules.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef TCP_CLIENT_SEGMENT_ENGINE_DEFINES_SVH
`define TCP_CLIENT_SEGMENT_ENGINE_DEFINES_SVH

// check a condition at every clock edge outside reset
`define TCSE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// check a consequence in the cycle after an antecedent
`define TCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tcse_pkg.sv =====
// Types, codes and helpers for the TCP client segment engine.
// No dependencies; imported by every module of the block.
package tcse_pkg;

	localparam int MAX_PACKET = 2048;
	localparam int SEND_LIMIT_RAW = MAX_PACKET - 40;
	localparam int SEND_LIMIT = (SEND_LIMIT_RAW > 2047) ? 2047 : SEND_LIMIT_RAW;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_OPEN    = 2'd0;
	localparam logic [1:0] CMD_SEND    = 2'd1;
	localparam logic [1:0] CMD_SEGMENT = 2'd2;
	localparam logic [1:0] CMD_TIMEOUT = 2'd3;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_IGNORED = 3'd1;
	localparam logic [2:0] EV_DATA    = 3'd2;
	localparam logic [2:0] EV_RESET   = 3'd3;
	localparam logic [2:0] EV_FAIL    = 3'd4;
	localparam logic [2:0] EV_DONE    = 3'd5;

	localparam logic [1:0] REG_LOCAL_PORT  = 2'd0;
	localparam logic [1:0] REG_PEER_PORT   = 2'd1;
	localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [7:0] FLAG_PSH = 8'h08;
	localparam logic [7:0] FLAG_ACK = 8'h10;
	localparam logic [7:0] IP_VER_IHL = 8'h45;
	localparam logic [7:0] IP_PROTO_TCP = 8'h06;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [10:0]        send_len;
		logic               seg_bad;
		logic               seg_rst;
		logic               seg_syn;
		logic               pay_pos;
		logic               long_pkt;
		logic signed [12:0] rc;
		logic [31:0]        seg_seq;
		logic [31:0]        seg_ack;
	} entry_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_flags;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic [10:0] tx_payload_len;
		logic [2:0]  event_res;
		logic [10:0] rx_len;
	} result_t;

	function automatic logic [7:0] tx_flags_for(input logic [31:0] seq, input logic has_len);
		logic [7:0] fl;
		if (seq == 32'd1) fl = FLAG_SYN;
		else if (has_len) fl = FLAG_ACK | FLAG_PSH;
		else fl = FLAG_ACK;
		return fl;
	endfunction

endpackage

// ===== hdl/tcse_front.sv =====
// Front end: classifies each request (packet checks, length clamp, payload size).
// Depends on tcse_pkg.
module tcse_front import tcse_pkg::*; (
	input  logic [1:0]  cmd,
	input  logic [10:0] send_len,
	input  logic [11:0] pkt_len,
	input  logic [7:0]  ver_ihl,
	input  logic [7:0]  ip_protocol,
	input  logic [15:0] seg_src_port,
	input  logic [15:0] seg_dst_port,
	input  logic [7:0]  seg_flags,
	input  logic [7:0]  offset_byte,
	input  logic [31:0] seg_seq,
	input  logic [31:0] seg_ack,
	input  logic [15:0] local_port,
	input  logic [15:0] peer_port,
	output entry_t      entry
);

	logic [5:0]         hdr_size;
	logic signed [12:0] rc;
	logic               len_bad;

	assign hdr_size = offset_byte[7:2];
	assign rc = $signed({1'b0, pkt_len}) - 13'sd20 - $signed({7'd0, hdr_size});
	assign len_bad = (pkt_len < 12'd40) || (32'(pkt_len) > MAX_PACKET);

	always_comb begin
		entry.cmd = cmd;
		entry.send_len = (32'(send_len) > SEND_LIMIT) ? 11'(SEND_LIMIT) : send_len;
		entry.seg_bad = len_bad || (ver_ihl != IP_VER_IHL) || (ip_protocol != IP_PROTO_TCP)
			|| (seg_src_port != peer_port) || (seg_dst_port != local_port);
		entry.seg_rst = |(seg_flags & FLAG_RST);
		entry.seg_syn = |(seg_flags & FLAG_SYN);
		entry.pay_pos = (rc > 13'sd0);
		entry.long_pkt = (pkt_len > 12'd40);
		entry.rc = rc;
		entry.seg_seq = seg_seq;
		entry.seg_ack = seg_ack;
	end

endmodule

// ===== hdl/tcse_queue.sv =====
// Two-entry request queue between the front end and the back end.
// Depends on tcse_pkg and the assertion macro header.
`include "tcp_client_segment_engine_defines.svh"
module tcse_queue import tcse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_data
);

	entry_t     mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'(QUEUE_DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`TCSE_ASSERT(a_count_bound, count_q <= 2'(QUEUE_DEPTH), "queue count overflow")
	`TCSE_ASSERT(a_no_push_full, !(push && full), "push into full queue")
	`TCSE_ASSERT_NEXT(a_pop_drains, pop && !push, count_q == 2'($past(count_q) - 2'd1), "pop did not drain")

endmodule

// ===== hdl/tcse_back.sv =====
// Back end: connection state, transmit header and event generation, output register.
// Depends on tcse_pkg and the assertion macro header.
`include "tcp_client_segment_engine_defines.svh"
module tcse_back import tcse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] max_retries,
	input  logic       head_valid,
	input  entry_t     head_data,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output result_t    result
);

	logic [31:0] send_seq_q, send_seq_d;
	logic [31:0] recv_ack_q, recv_ack_d;
	logic        awaiting_q, awaiting_d;
	logic [3:0]  retry_q, retry_d;
	logic [10:0] pending_q, pending_d;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res_d;
	logic [31:0] ss_adv;
	logic [10:0] rx_val;

	assign pop = head_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result = res_q;
	assign ss_adv = (send_seq_q < head_data.seg_ack) ? head_data.seg_ack : send_seq_q;

	always_comb begin
		send_seq_d = send_seq_q;
		recv_ack_d = recv_ack_q;
		awaiting_d = awaiting_q;
		retry_d = retry_q;
		pending_d = pending_q;
		res_d = '0;
		rx_val = 11'd0;
		unique case (head_data.cmd)
			CMD_OPEN: begin
				send_seq_d = 32'd1;
				recv_ack_d = 32'd0;
				pending_d = 11'd0;
				retry_d = 4'd0;
				awaiting_d = 1'b1;
				res_d.tx_valid = 1'b1;
				res_d.tx_flags = FLAG_SYN;
				res_d.tx_seq = 32'd1;
			end
			CMD_SEND: begin
				res_d.tx_valid = 1'b1;
				res_d.tx_flags = tx_flags_for(send_seq_q, head_data.send_len != 11'd0);
				res_d.tx_seq = send_seq_q;
				res_d.tx_ack = recv_ack_q;
				res_d.tx_payload_len = head_data.send_len;
				if (send_seq_q <= 32'd1 || head_data.send_len != 11'd0) begin
					awaiting_d = 1'b1;
					retry_d = 4'd0;
					pending_d = head_data.send_len;
				end
			end
			CMD_SEGMENT: begin
				priority if (head_data.seg_bad) begin
					res_d.event_res = EV_IGNORED;
				end else if (head_data.seg_rst) begin
					awaiting_d = 1'b0;
					res_d.event_res = EV_RESET;
				end else if (send_seq_q == 32'd1) begin
					awaiting_d = 1'b0;
					if (head_data.seg_syn) begin
						send_seq_d = head_data.seg_ack;
						recv_ack_d = head_data.seg_seq + 32'd1;
						res_d.tx_valid = 1'b1;
						res_d.tx_flags = tx_flags_for(head_data.seg_ack, 1'b0);
						res_d.tx_seq = head_data.seg_ack;
						res_d.tx_ack = head_data.seg_seq + 32'd1;
						res_d.event_res = awaiting_q ? EV_DONE : EV_NONE;
					end else begin
						res_d.event_res = EV_FAIL;
					end
				end else begin
					send_seq_d = ss_adv;
					if (head_data.pay_pos) begin
						if (head_data.seg_seq >= recv_ack_q) begin
							rx_val = head_data.rc[10:0];
							recv_ack_d = head_data.seg_seq
								+ (head_data.long_pkt ? {20'd0, head_data.rc[11:0]} : 32'd0);
							res_d.tx_valid = 1'b1;
							res_d.tx_flags = tx_flags_for(ss_adv, 1'b0);
							res_d.tx_seq = ss_adv;
							res_d.tx_ack = recv_ack_d;
						end
					end
					if (head_data.rc < 13'sd0) begin
						res_d.event_res = EV_IGNORED;
					end else begin
						awaiting_d = 1'b0;
						res_d.rx_len = rx_val;
						if (awaiting_q) res_d.event_res = EV_DONE;
						else if (rx_val != 11'd0) res_d.event_res = EV_DATA;
						else res_d.event_res = EV_NONE;
					end
				end
			end
			CMD_TIMEOUT: begin
				if (awaiting_q) begin
					if (retry_q < max_retries) begin
						retry_d = retry_q + 4'd1;
						res_d.tx_valid = 1'b1;
						res_d.tx_flags = tx_flags_for(send_seq_q, pending_q != 11'd0);
						res_d.tx_seq = send_seq_q;
						res_d.tx_ack = recv_ack_q;
						res_d.tx_payload_len = pending_q;
					end else begin
						awaiting_d = 1'b0;
						res_d.event_res = EV_FAIL;
					end
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_seq_q <= 32'd0;
			recv_ack_q <= 32'd0;
			awaiting_q <= 1'b0;
			retry_q <= 4'd0;
			pending_q <= 11'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				send_seq_q <= send_seq_d;
				recv_ack_q <= recv_ack_d;
				awaiting_q <= awaiting_d;
				retry_q <= retry_d;
				pending_q <= pending_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= res_d;
	end

	`TCSE_ASSERT_NEXT(a_fail_ends_wait, pop && res_d.event_res == EV_FAIL, !awaiting_q, "failure kept wait")
	`TCSE_ASSERT(a_tx_flags_set, !(out_valid_q && res_q.tx_valid) || res_q.tx_flags != 8'h00, "empty tx flags")
	`TCSE_ASSERT_NEXT(a_open_waits, pop && head_data.cmd == CMD_OPEN, awaiting_q && send_seq_q == 32'd1, "open did not start wait")

endmodule

// ===== hdl/tcp_client_segment_engine.sv =====
// TCP client segment engine top level: configuration registers, front end, queue, back end.
// Depends on tcse_pkg, tcse_front, tcse_queue and tcse_back.
//
// Usage:
//   Requests enter on the in channel (in_valid / in_stall): open, send, a received
//   segment header or a timeout tick, selected by cmd. Every request yields exactly
//   one result on the out channel (out_valid / out_stall): an optional transmit
//   header (tx_valid, tx_flags, tx_seq, tx_ack, tx_payload_len) plus event_res
//   and rx_len.
//   The front end classifies a request in its accept cycle and writes it into a
//   two-entry queue; the back end updates the connection state and loads the
//   output register. A result passes from its queue entry to the output register,
//   and throughput is one request per cycle while out_stall is low. When the
//   receiver stalls, the output register holds, the queue fills, and in_stall
//   rises once both queue entries are taken.
//   Configuration (local_port, peer_port, max_retries) is written through
//   cfg_we / cfg_index / cfg_data while the engine is idle.
//   Reset clears all connection state and the queue; max_retries resets to 5.
module tcp_client_segment_engine import tcse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [10:0] send_len,
	input  logic [11:0] pkt_len,
	input  logic [7:0]  ver_ihl,
	input  logic [7:0]  ip_protocol,
	input  logic [15:0] seg_src_port,
	input  logic [15:0] seg_dst_port,
	input  logic [7:0]  seg_flags,
	input  logic [7:0]  offset_byte,
	input  logic [31:0] seg_seq,
	input  logic [31:0] seg_ack,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_flags,
	output logic [31:0] tx_seq,
	output logic [31:0] tx_ack,
	output logic [10:0] tx_payload_len,
	output logic [2:0]  event_res,
	output logic [10:0] rx_len
);

	logic [15:0] local_port_q;
	logic [15:0] peer_port_q;
	logic [3:0]  max_retries_q;
	entry_t      front_entry;
	entry_t      head_data;
	logic        q_full;
	logic        head_valid;
	logic        pop;
	result_t     result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q <= 16'd0;
			peer_port_q <= 16'd0;
			max_retries_q <= 4'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_PORT: local_port_q <= cfg_data;
				REG_PEER_PORT: peer_port_q <= cfg_data;
				REG_MAX_RETRIES: max_retries_q <= cfg_data[3:0];
				default: max_retries_q <= max_retries_q;
			endcase
		end
	end

	assign in_stall = q_full;

	tcse_front u_front (
		.cmd          (cmd),
		.send_len     (send_len),
		.pkt_len      (pkt_len),
		.ver_ihl      (ver_ihl),
		.ip_protocol  (ip_protocol),
		.seg_src_port (seg_src_port),
		.seg_dst_port (seg_dst_port),
		.seg_flags    (seg_flags),
		.offset_byte  (offset_byte),
		.seg_seq      (seg_seq),
		.seg_ack      (seg_ack),
		.local_port   (local_port_q),
		.peer_port    (peer_port_q),
		.entry        (front_entry)
	);

	tcse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !q_full),
		.push_data  (front_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	tcse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_retries (max_retries_q),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result)
	);

	assign tx_valid = result.tx_valid;
	assign tx_flags = result.tx_flags;
	assign tx_seq = result.tx_seq;
	assign tx_ack = result.tx_ack;
	assign tx_payload_len = result.tx_payload_len;
	assign event_res = result.event_res;
	assign rx_len = result.rx_len;

endmodule
